>>> sv/spe_pkg.sv
// spe_pkg: shared types and constants of the spi slave packet endpoint
// no dependencies; imported by every module of the block
package spe_pkg;

    localparam int FRAME_BYTES = 21;
    localparam int CNT_W = 5;
    localparam int ADDR_W = 5;

    localparam logic [7:0] START_RESET = 8'd2;
    localparam logic [7:0] DELIM_RESET = 8'd31;
    localparam logic [7:0] END_RESET = 8'd3;
    localparam logic [31:0] OWN_ADDR_RESET = 32'd0;
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;

    localparam logic [CNT_W-1:0] LAST_RX_POS = CNT_W'(FRAME_BYTES - 1);
    localparam logic [CNT_W-1:0] TX_END_POS = CNT_W'(FRAME_BYTES);

    typedef enum logic [2:0] {
        REG_START    = 3'd0,
        REG_DELIM    = 3'd1,
        REG_END      = 3'd2,
        REG_OWN_ADDR = 3'd3,
        REG_TIMEOUT  = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        CMD_RX       = 2'd0,
        CMD_TICK     = 2'd1,
        CMD_REPLY    = 2'd2,
        CMD_NO_REPLY = 2'd3
    } item_cmd_t;

    typedef enum logic [2:0] {
        EV_NONE          = 3'd0,
        EV_REQUEST       = 3'd1,
        EV_TX            = 3'd2,
        EV_FRAME_ERROR   = 3'd3,
        EV_ADDR_MISMATCH = 3'd4,
        EV_TIMEOUT       = 3'd5,
        EV_REPLY_DONE    = 3'd6
    } event_t;

    typedef enum logic [1:0] {
        PH_RECEIVING  = 2'd0,
        PH_AWAITING   = 2'd1,
        PH_RESPONDING = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [7:0]  delim_byte;
        logic [7:0]  end_byte;
        logic [31:0] own_address;
        logic [15:0] timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic   accept;
        logic   clear_all;
        logic   touch;
        logic   store_byte;
        logic   frame_done;
        logic   tick;
        logic   load_reply;
        logic   send_tx;
        logic   drive;
        event_t ev;
    } ctrl_cmd_t;

    typedef struct packed {
        logic rx_last;
        logic frame_good;
        logic addr_match;
        logic tx_done;
        logic active;
        logic timeout_hit;
    } dp_status_t;

endpackage

>>> sv/spe_if.sv
// spe_item_if and spe_result_if: valid/ready request channels of the endpoint
// no dependencies
interface spe_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [7:0]  rx_byte;
    logic [31:0] reply_payload;

    modport source (output valid, output cmd, output rx_byte, output reply_payload,
                    input ready);
    modport sink (input valid, input cmd, input rx_byte, input reply_payload,
                  output ready);
endinterface

interface spe_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [31:0] req_command;
    logic [31:0] req_parameter;
    logic [31:0] req_payload;
    logic [7:0]  tx_byte;
    logic        drive_enable;

    modport source (output valid, output event_res, output req_command,
                    output req_parameter, output req_payload, output tx_byte,
                    output drive_enable, input ready);
    modport sink (input valid, input event_res, input req_command,
                  input req_parameter, input req_payload, input tx_byte,
                  input drive_enable, output ready);
endinterface

>>> sv/spe_regs.sv
// spe_regs: apb configuration registers of the endpoint
// depends on spe_pkg
module spe_regs
    import spe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    reg_index_t index;
    logic       wr_en;

    assign index = reg_index_t'(paddr[ADDR_W-1:2]);
    assign wr_en = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte  <= START_RESET;
            cfg_reg.delim_byte  <= DELIM_RESET;
            cfg_reg.end_byte    <= END_RESET;
            cfg_reg.own_address <= OWN_ADDR_RESET;
            cfg_reg.timeout_ms  <= TIMEOUT_RESET;
        end
        else if (wr_en)
        begin
            unique case (index)
                REG_START:    cfg_reg.start_byte  <= pwdata[7:0];
                REG_DELIM:    cfg_reg.delim_byte  <= pwdata[7:0];
                REG_END:      cfg_reg.end_byte    <= pwdata[7:0];
                REG_OWN_ADDR: cfg_reg.own_address <= pwdata;
                REG_TIMEOUT:  cfg_reg.timeout_ms  <= pwdata[15:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_START:    prdata = {24'd0, cfg_reg.start_byte};
            REG_DELIM:    prdata = {24'd0, cfg_reg.delim_byte};
            REG_END:      prdata = {24'd0, cfg_reg.end_byte};
            REG_OWN_ADDR: prdata = cfg_reg.own_address;
            REG_TIMEOUT:  prdata = {16'd0, cfg_reg.timeout_ms};
            default:      prdata = 32'd0;
        endcase
    end

endmodule

>>> sv/spe_ctrl.sv
// spe_ctrl: phase state machine of the endpoint, issues datapath commands
// depends on spe_pkg
module spe_ctrl
    import spe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [1:0] item_cmd,
    input  dp_status_t st,
    output ctrl_cmd_t  cmd
);

    phase_t phase_reg;
    phase_t phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_RECEIVING;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        cmd = '0;
        cmd.ev = EV_NONE;
        cmd.accept = accept;
        if (accept)
        begin
            case (item_cmd)
                CMD_RX:
                begin
                    cmd.touch = 1'b1;
                    unique case (phase_reg)
                        PH_RESPONDING:
                        begin
                            if (st.tx_done)
                            begin
                                cmd.clear_all = 1'b1;
                                cmd.ev = EV_REPLY_DONE;
                                phase_next = PH_RECEIVING;
                            end
                            else
                            begin
                                cmd.send_tx = 1'b1;
                                cmd.ev = EV_TX;
                            end
                        end
                        PH_AWAITING: ;
                        PH_RECEIVING:
                        begin
                            cmd.store_byte = 1'b1;
                            if (st.rx_last)
                            begin
                                if (!st.frame_good)
                                begin
                                    cmd.clear_all = 1'b1;
                                    cmd.ev = EV_FRAME_ERROR;
                                end
                                else if (!st.addr_match)
                                begin
                                    cmd.clear_all = 1'b1;
                                    cmd.ev = EV_ADDR_MISMATCH;
                                end
                                else
                                begin
                                    cmd.frame_done = 1'b1;
                                    cmd.ev = EV_REQUEST;
                                    phase_next = PH_AWAITING;
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = PH_RECEIVING;
                        end
                    endcase
                end
                CMD_TICK:
                begin
                    if (st.active)
                    begin
                        cmd.tick = 1'b1;
                        if (st.timeout_hit)
                        begin
                            cmd.clear_all = 1'b1;
                            cmd.ev = EV_TIMEOUT;
                            phase_next = PH_RECEIVING;
                        end
                    end
                end
                CMD_REPLY:
                begin
                    if (phase_reg == PH_AWAITING)
                    begin
                        cmd.load_reply = 1'b1;
                        cmd.ev = EV_TX;
                        phase_next = PH_RESPONDING;
                    end
                end
                default:
                begin
                    if (phase_reg == PH_AWAITING)
                    begin
                        phase_next = PH_RECEIVING;
                    end
                end
            endcase
        end
        cmd.drive = (phase_next == PH_RESPONDING);
    end

`ifndef SYNTH
    a_resp_holds: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item_cmd == CMD_RX && phase_reg == PH_RESPONDING && !st.tx_done
        |=> phase_reg == PH_RESPONDING)
        else $error("responding phase left before the answer frame was sent");
`endif

endmodule

>>> sv/spe_dp.sv
// spe_dp: frame capture, framing check, answer byte select and result register
// depends on spe_pkg; driven by spe_ctrl commands
module spe_dp
    import spe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  ctrl_cmd_t   cmd,
    input  logic [7:0]  rx_byte,
    input  logic [31:0] reply_payload,
    output dp_status_t  st,
    output logic [2:0]  event_res,
    output logic [31:0] req_command,
    output logic [31:0] req_parameter,
    output logic [31:0] req_payload,
    output logic [7:0]  tx_byte,
    output logic        drive_enable
);

    logic [CNT_W-1:0] rx_count_reg;
    logic [CNT_W-1:0] tx_count_reg;
    logic             active_reg;
    logic [15:0]      elapsed_reg;
    logic [15:0]      elapsed_next;

    logic [7:0]  fb_start_reg;
    logic [7:0]  fb_d1_reg;
    logic [7:0]  fb_d2_reg;
    logic [7:0]  fb_d3_reg;
    logic [31:0] addr_sr_reg;
    logic [31:0] command_sr_reg;
    logic [31:0] param_sr_reg;
    logic [31:0] payload_sr_reg;

    logic [31:0] held_address_reg;
    logic [31:0] held_command_reg;
    logic [31:0] held_parameter_reg;
    logic [31:0] held_reply_reg;

    logic [2:0]  event_reg;
    logic [31:0] req_command_reg;
    logic [31:0] req_parameter_reg;
    logic [31:0] req_payload_reg;
    logic [7:0]  tx_byte_reg;
    logic        drive_reg;

    logic [CNT_W-1:0] tx_pos;
    logic [31:0]      ans_word;
    logic [2:0]       ans_lane;
    logic [7:0]       ans_byte;
    logic             start_ok;
    logic             delim_ok;
    logic             end_ok;

    // saturating millisecond count
    assign elapsed_next = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;

    assign start_ok = (cfg.start_byte == 8'd0) || (fb_start_reg == cfg.start_byte);
    assign delim_ok = (cfg.delim_byte == 8'd0) ||
                      ((fb_d1_reg == cfg.delim_byte) && (fb_d2_reg == cfg.delim_byte) &&
                       (fb_d3_reg == cfg.delim_byte));
    assign end_ok = (cfg.end_byte == 8'd0) || (rx_byte == cfg.end_byte);

    assign st.rx_last = (rx_count_reg == LAST_RX_POS);
    assign st.frame_good = start_ok && delim_ok && end_ok;
    assign st.addr_match = (addr_sr_reg == cfg.own_address);
    assign st.tx_done = (tx_count_reg == TX_END_POS);
    assign st.active = active_reg;
    assign st.timeout_hit = (elapsed_next > cfg.timeout_ms);

    // answer frame byte
    assign tx_pos = cmd.load_reply ? '0 : tx_count_reg;

    always_comb
    begin
        ans_word = held_address_reg;
        ans_lane = 3'd0;
        unique case (tx_pos) inside
            [5'd1:5'd4]:
            begin
                ans_word = held_address_reg;
                ans_lane = 3'(tx_pos - 5'd1);
            end
            [5'd6:5'd9]:
            begin
                ans_word = held_command_reg;
                ans_lane = 3'(tx_pos - 5'd6);
            end
            [5'd11:5'd14]:
            begin
                ans_word = held_parameter_reg;
                ans_lane = 3'(tx_pos - 5'd11);
            end
            [5'd16:5'd19]:
            begin
                ans_word = held_reply_reg;
                ans_lane = 3'(tx_pos - 5'd16);
            end
            default: ;
        endcase
    end

    always_comb
    begin
        unique case (tx_pos) inside
            5'd0:                ans_byte = cfg.start_byte;
            5'd5, 5'd10, 5'd15:  ans_byte = cfg.delim_byte;
            5'd20:               ans_byte = cfg.end_byte;
            [5'd21:5'd31]:       ans_byte = 8'd0;
            default:
            begin
                case (ans_lane)
                    3'd0:    ans_byte = ans_word[31:24];
                    3'd1:    ans_byte = ans_word[23:16];
                    3'd2:    ans_byte = ans_word[15:8];
                    default: ans_byte = ans_word[7:0];
                endcase
            end
        endcase
    end

    // control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_count_reg <= '0;
            tx_count_reg <= '0;
            active_reg   <= 1'b0;
            elapsed_reg  <= '0;
        end
        else if (cmd.clear_all)
        begin
            rx_count_reg <= '0;
            tx_count_reg <= '0;
            active_reg   <= 1'b0;
            elapsed_reg  <= '0;
        end
        else
        begin
            if (cmd.touch && !active_reg)
            begin
                active_reg  <= 1'b1;
                elapsed_reg <= '0;
            end
            if (cmd.tick)
            begin
                elapsed_reg <= elapsed_next;
            end
            if (cmd.store_byte && !st.rx_last)
            begin
                rx_count_reg <= rx_count_reg + 5'd1;
            end
            if (cmd.frame_done)
            begin
                active_reg   <= 1'b0;
                rx_count_reg <= '0;
            end
            if (cmd.load_reply)
            begin
                tx_count_reg <= 5'd1;
            end
            if (cmd.send_tx)
            begin
                tx_count_reg <= tx_count_reg + 5'd1;
            end
        end
    end

    // frame capture
    always_ff @(posedge clk)
    begin
        if (cmd.store_byte)
        begin
            unique case (rx_count_reg) inside
                5'd0:          fb_start_reg   <= rx_byte;
                [5'd1:5'd4]:   addr_sr_reg    <= {addr_sr_reg[23:0], rx_byte};
                5'd5:          fb_d1_reg      <= rx_byte;
                [5'd6:5'd9]:   command_sr_reg <= {command_sr_reg[23:0], rx_byte};
                5'd10:         fb_d2_reg      <= rx_byte;
                [5'd11:5'd14]: param_sr_reg   <= {param_sr_reg[23:0], rx_byte};
                5'd15:         fb_d3_reg      <= rx_byte;
                [5'd16:5'd19]: payload_sr_reg <= {payload_sr_reg[23:0], rx_byte};
                default:       ;
            endcase
        end
        if (cmd.frame_done)
        begin
            held_address_reg   <= addr_sr_reg;
            held_command_reg   <= command_sr_reg;
            held_parameter_reg <= param_sr_reg;
        end
        if (cmd.load_reply)
        begin
            held_reply_reg <= reply_payload;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            event_reg         <= cmd.ev;
            req_command_reg   <= (cmd.ev == EV_REQUEST) ? command_sr_reg : 32'd0;
            req_parameter_reg <= (cmd.ev == EV_REQUEST) ? param_sr_reg : 32'd0;
            req_payload_reg   <= (cmd.ev == EV_REQUEST) ? payload_sr_reg : 32'd0;
            tx_byte_reg       <= (cmd.ev == EV_TX) ? ans_byte : 8'd0;
            drive_reg         <= cmd.drive;
        end
    end

    assign event_res = event_reg;
    assign req_command = req_command_reg;
    assign req_parameter = req_parameter_reg;
    assign req_payload = req_payload_reg;
    assign tx_byte = tx_byte_reg;
    assign drive_enable = drive_reg;

`ifndef SYNTH
    a_rx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rx_count_reg <= LAST_RX_POS)
        else $error("receive position ran past the end of the frame");
    a_tx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tx_count_reg <= TX_END_POS)
        else $error("answer position ran past the end of the frame");
    a_reply_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_reply |=> tx_count_reg == 5'd1 && !cmd.load_reply)
        else $error("answer did not start at its second byte after a reply");
`endif

endmodule

>>> sv/spi_slave_packet_endpoint_unit.sv
// spi_slave_packet_endpoint_unit: top level of the spi slave packet endpoint
// depends on spe_pkg, spe_if, spe_regs, spe_ctrl and spe_dp
//
//   channel   dir  handshake      payload
//   item      in   valid/ready    cmd, rx_byte, reply_payload
//   result    out  valid/ready    event_res, req_*, tx_byte, drive_enable
//   apb       in   psel/penable   paddr, pwdata -> prdata (pready tied high)
//
// one item per cycle: each item is decoded and its result registered in the
// accepting cycle; the single result register sets the rate
// a result waiting on result.ready blocks the next item until taken
// rst_n clears the phase, counters and configuration; no clearing pass
module spi_slave_packet_endpoint_unit
    import spe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    spe_item_if.sink          item,
    spe_result_if.source      result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    dp_status_t st;
    logic       accept;
    logic       out_valid_reg;

    assign item.ready = !out_valid_reg || result.ready;
    assign accept = item.valid && item.ready;
    assign result.valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    spe_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    spe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item_cmd (item.cmd),
        .st       (st),
        .cmd      (cmd)
    );

    spe_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd           (cmd),
        .rx_byte       (item.rx_byte),
        .reply_payload (item.reply_payload),
        .st            (st),
        .event_res     (result.event_res),
        .req_command   (result.req_command),
        .req_parameter (result.req_parameter),
        .req_payload   (result.req_payload),
        .tx_byte       (result.tx_byte),
        .drive_enable  (result.drive_enable)
    );

`ifndef SYNTH
    a_result_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted request produced no result");
`endif

endmodule
